### design/grm_pkg.sv
// shared types and constants for the grid rectangle merger
package grm_pkg;

    localparam int COLUMN_W    = 32;
    localparam int COL_FIELD_W = 8;
    localparam int ROW_FIELD_W = 5;
    localparam int CFG_W       = 6;
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_USER_W  = 2;

    // output tdata field offsets
    localparam int OUT_FIRST_LSB = 0;
    localparam int OUT_LAST_LSB  = 8;
    localparam int OUT_TOP_LSB   = 16;
    localparam int OUT_BOT_LSB   = 21;

    // output tuser bits
    localparam int USER_RECT_BIT = 0;
    localparam int USER_OVF_BIT  = 1;

    localparam logic [CFG_W-1:0] ROWS_RESET = 6'd32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CLOSE,
        S_COMMIT,
        S_FINAL,
        S_MARK
    } t_grm_state;

    // per-row flags from one lane
    typedef struct packed {
        logic fail;       // covered row that is not solid in this column
        logic seg_start;  // row starts a span, or is outside every span
        logic seg_end;    // last row of an open span
    } t_lane_bits;

endpackage

### design/grm_row_lane.sv
// one row lane: local span and fail flags of a single grid row
module grm_row_lane (
    input  logic                  i_cell,
    input  logic                  i_cover,
    input  logic                  i_head,
    input  logic                  i_cover_up,
    input  logic                  i_head_up,
    output grm_pkg::t_lane_bits   o_bits
);
    import grm_pkg::*;

    t_lane_bits w_bits;

    always_comb begin
        w_bits.fail      = i_cover & ~i_cell;
        w_bits.seg_start = i_head | ~i_cover;
        // span stops where the next row is free or heads another span
        w_bits.seg_end   = i_cover & (~i_cover_up | i_head_up);
    end

    assign o_bits = w_bits;

endmodule

### design/grm_span_merge.sv
// merges lane flags: grow or close per span, then opens new runs
module grm_span_merge #(
    parameter int N = 32
) (
    input  grm_pkg::t_lane_bits i_lanes [N],
    input  logic [N-1:0]        i_col,
    input  logic [N-1:0]        i_cover,
    input  logic [N-1:0]        i_heads,
    output logic [N-1:0]        o_close_heads,
    output logic [N-1:0]        o_ends,
    output logic [N-1:0]        o_run_heads,
    output logic [N-1:0]        o_next_cover,
    output logic [N-1:0]        o_next_heads
);
    import grm_pkg::*;

    localparam int LEVELS = $clog2(N);

    always_comb begin
        logic [N-1:0] fv, ef, sv, sf, nv, nf, ends_raw, cl_heads, cl_rows, taken, free;
        for (int r = 0; r < N; r++) begin
            fv[r]       = i_lanes[r].fail;
            ends_raw[r] = i_lanes[r].seg_end;
            sf[r]       = i_lanes[r].seg_start;
        end
        ef = ends_raw;
        // segmented or toward higher rows: each row sees fails up to its span end
        for (int l = 0; l < LEVELS; l++) begin
            nv = fv;
            nf = ef;
            for (int r = 0; r < N; r++) begin
                if ((r + (1 << l) < N) && !ef[r]) begin
                    nv[r] = fv[r] | fv[r + (1 << l)];
                    nf[r] = ef[r + (1 << l)];
                end
            end
            fv = nv;
            ef = nf;
        end
        cl_heads = i_heads & fv;
        // spread the close flag from each head down its span
        sv = cl_heads;
        for (int l = 0; l < LEVELS; l++) begin
            nv = sv;
            nf = sf;
            for (int r = 0; r < N; r++) begin
                if ((r >= (1 << l)) && !sf[r]) begin
                    nv[r] = sv[r] | sv[r - (1 << l)];
                    nf[r] = sf[r - (1 << l)];
                end
            end
            sv = nv;
            sf = nf;
        end
        cl_rows = i_cover & sv;
        taken   = i_cover & ~cl_rows;
        free    = i_col & ~taken;

        o_close_heads = cl_heads;
        o_ends        = ends_raw;
        o_run_heads   = free & ~(free << 1);
        o_next_cover  = taken | free;
        o_next_heads  = (i_heads & ~cl_heads) | (free & ~(free << 1));
    end

endmodule

### design/grm_emit_pick.sv
// picks the lowest pending span head and the bottom row of its span
module grm_emit_pick #(
    parameter int N = 32
) (
    input  logic [N-1:0]          i_pend,
    input  logic [N-1:0]          i_ends,
    output logic [$clog2(N)-1:0]  o_top,
    output logic [$clog2(N)-1:0]  o_bot,
    output logic                  o_last
);
    localparam int RW = $clog2(N);

    logic [N-1:0] w_low_oh;
    logic [N-1:0] w_above;
    logic [N-1:0] w_bot_cand;
    logic [N-1:0] w_bot_oh;

    assign w_low_oh   = i_pend & (~i_pend + N'(1));
    assign w_above    = ~(w_low_oh - N'(1));
    assign w_bot_cand = i_ends & w_above;
    assign w_bot_oh   = w_bot_cand & (~w_bot_cand + N'(1));
    assign o_last     = (i_pend & ~w_low_oh) == '0;

    always_comb begin
        o_top = '0;
        o_bot = '0;
        for (int r = 0; r < N; r++) begin
            if (w_low_oh[r]) o_top = o_top | RW'(r);
            if (w_bot_oh[r]) o_bot = o_bot | RW'(r);
        end
    end

endmodule

### design/grid_rectangle_merger_core.sv
// top level of the greedy grid rectangle merger
//
// usage: a grid enters one column per beat on the s_axis side, tdata holding
// the column mask (bit r = row r solid) and tlast marking the last column.
// every rectangle that closes leaves as one beat on the m_axis side: tdata
// carries the column and row span, tuser says rectangle or empty end marker
// plus the sticky column overflow flag, tlast marks the final beat of a grid.
// a grid with no solid cell ends in a single empty marker beat.
//
// timing: with the receiver ready a column passes through take, evaluate,
// close sweep and commit, the sweep handing out each rectangle it closes; on the last
// column every rectangle still open follows (or the end marker instead).
// closes plus rectangles left open never exceed rows in use. the single output
// register hands out one rectangle per cycle while the receiver is ready.
// closing rectangles come out by rising top row, then the rectangles still
// open on the last column, again by rising top row.
//
// rows_in_use is written through i_cfg_wr_en / i_cfg_wr_data; the user keeps these
// writes between grids, the block does not enforce it. reset (synchronous, active
// low) empties the open set, clears the column counter and sets rows_in_use to 32.
// when the receiver stalls the output beat holds and the block waits in place; the
// next column is still taken once the current one has finished, with a beat left waiting.
module grid_rectangle_merger_core #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [grm_pkg::CFG_W-1:0]         i_cfg_wr_data,    // rows_in_use
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [grm_pkg::COLUMN_W-1:0]      i_s_axis_tdata,   // [31:0] column_cells
    input  logic                              i_s_axis_tlast,   // final_column
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [7:0] first_col, [15:8] last_col, [20:16] top_row, [25:21] bottom_row
    output logic [grm_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic [grm_pkg::OUT_USER_W-1:0]    o_m_axis_tuser,   // [0] rect_valid, [1] column_overflow
    output logic                              o_m_axis_tlast    // grid_done
);
    import grm_pkg::*;

    // rows above the column width can never be solid
    localparam int LIVE_ROWS = (MAX_ROWS < COLUMN_W) ? MAX_ROWS : COLUMN_W;
    localparam int RW        = $clog2(LIVE_ROWS);
    localparam int CW        = $clog2(MAX_COLS + 1);
    localparam logic [CW-1:0] COL_LIMIT   = CW'(MAX_COLS);
    localparam logic [CW-1:0] COL_SAT_IDX = CW'(MAX_COLS - 1);

    // control state
    t_grm_state              r_state, n_state;
    logic [CFG_W-1:0]        r_rows;
    logic [CW-1:0]           r_col_cnt;
    logic                    r_ovf;
    logic                    r_any;
    logic [LIVE_ROWS-1:0]    r_cover;
    logic [LIVE_ROWS-1:0]    r_heads;
    logic [LIVE_ROWS-1:0]    r_pend;
    logic                    r_ovalid;

    // column payload
    logic [LIVE_ROWS-1:0]    r_col;
    logic                    r_fin;
    logic [COL_FIELD_W-1:0]  r_idx;
    logic [COL_FIELD_W-1:0]  r_prev;
    logic [LIVE_ROWS-1:0]    r_run_heads;
    logic [LIVE_ROWS-1:0]    r_ends;
    logic [COL_FIELD_W-1:0]  r_start_col [LIVE_ROWS];

    // output beat
    logic [OUT_DATA_W-1:0]   r_odata, n_odata;
    logic [OUT_USER_W-1:0]   r_ouser, n_ouser;
    logic                    r_olast;

    logic                    w_in_acc;
    logic                    w_slot_free;
    logic                    w_sat;
    logic [CW-1:0]           w_idx;
    logic [CW-1:0]           w_prev;
    logic [LIVE_ROWS-1:0]    w_row_mask;
    logic [LIVE_ROWS-1:0]    w_cover_up;
    logic [LIVE_ROWS-1:0]    w_heads_up;
    t_lane_bits              w_lanes [LIVE_ROWS];
    logic [LIVE_ROWS-1:0]    m_close_heads;
    logic [LIVE_ROWS-1:0]    m_ends;
    logic [LIVE_ROWS-1:0]    m_run_heads;
    logic [LIVE_ROWS-1:0]    m_next_cover;
    logic [LIVE_ROWS-1:0]    m_next_heads;
    logic [RW-1:0]           w_top;
    logic [RW-1:0]           w_bot;
    logic                    w_pick_last;

    // sequencer strobes and emitted fields
    logic                    w_eval;
    logic                    w_commit;
    logic                    w_emit;
    logic                    w_clear;
    logic [COL_FIELD_W-1:0]  e_first;
    logic [COL_FIELD_W-1:0]  e_last;
    logic [ROW_FIELD_W-1:0]  e_top;
    logic [ROW_FIELD_W-1:0]  e_bot;
    logic                    e_valid;
    logic                    e_done;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_slot_free     = ~r_ovalid | i_m_axis_tready;

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

    // column index saturates at the last column
    assign w_sat  = (r_col_cnt >= COL_LIMIT);
    assign w_idx  = w_sat ? COL_SAT_IDX : r_col_cnt;
    assign w_prev = (w_idx == '0) ? '0 : w_idx - CW'(1);

    // rows in use; a zero count still keeps row 0
    always_comb begin
        for (int r = 0; r < LIVE_ROWS; r++) begin
            w_row_mask[r] = (r == 0) || (r < int'(r_rows));
        end
    end

    // neighbor view for the lanes, nothing above the top row
    assign w_cover_up = r_cover >> 1;
    assign w_heads_up = r_heads >> 1;

    for (genvar g = 0; g < LIVE_ROWS; g++) begin : g_lane
        grm_row_lane u_lane (
            .i_cell     (r_col[g]),
            .i_cover    (r_cover[g]),
            .i_head     (r_heads[g]),
            .i_cover_up (w_cover_up[g]),
            .i_head_up  (w_heads_up[g]),
            .o_bits     (w_lanes[g])
        );
    end

    grm_span_merge #(
        .N (LIVE_ROWS)
    ) u_merge (
        .i_lanes       (w_lanes),
        .i_col         (r_col),
        .i_cover       (r_cover),
        .i_heads       (r_heads),
        .o_close_heads (m_close_heads),
        .o_ends        (m_ends),
        .o_run_heads   (m_run_heads),
        .o_next_cover  (m_next_cover),
        .o_next_heads  (m_next_heads)
    );

    grm_emit_pick #(
        .N (LIVE_ROWS)
    ) u_pick (
        .i_pend (r_pend),
        .i_ends (r_ends),
        .o_top  (w_top),
        .o_bot  (w_bot),
        .o_last (w_pick_last)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_CLOSE;
            end
            S_CLOSE: begin
                if (r_pend == '0) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_heads != '0) begin
                    n_state = S_FINAL;
                end else if (r_any) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MARK;
                end
            end
            S_FINAL: begin
                if (w_slot_free && w_pick_last) n_state = S_IDLE;
            end
            S_MARK: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_eval   = 1'b0;
        w_commit = 1'b0;
        w_emit   = 1'b0;
        w_clear  = 1'b0;
        e_first  = r_start_col[w_top];
        e_last   = r_prev;
        e_top    = ROW_FIELD_W'(w_top);
        e_bot    = ROW_FIELD_W'(w_bot);
        e_valid  = 1'b1;
        e_done   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_EVAL: begin
                w_eval = 1'b1;
            end
            S_CLOSE: begin
                if ((r_pend != '0) && w_slot_free) begin
                    w_emit = 1'b1;
                    // last close of the grid ends it when nothing stays open
                    e_done = r_fin && w_pick_last && (r_heads == '0);
                end
            end
            S_COMMIT: begin
                w_commit = 1'b1;
                w_clear  = r_fin && (r_heads == '0) && r_any;
            end
            S_FINAL: begin
                if (w_slot_free) begin
                    w_emit  = 1'b1;
                    e_last  = r_idx;
                    e_done  = w_pick_last;
                    w_clear = w_pick_last;
                end
            end
            S_MARK: begin
                if (w_slot_free) begin
                    w_emit  = 1'b1;
                    e_first = '0;
                    e_last  = '0;
                    e_top   = '0;
                    e_bot   = '0;
                    e_valid = 1'b0;
                    e_done  = 1'b1;
                    w_clear = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_odata = OUT_DATA_W'({e_bot, e_top, e_last, e_first});
        n_ouser = '0;
        n_ouser[USER_RECT_BIT] = e_valid;
        n_ouser[USER_OVF_BIT]  = r_ovf;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rows    <= ROWS_RESET;
            r_col_cnt <= '0;
            r_ovf     <= 1'b0;
            r_any     <= 1'b0;
            r_cover   <= '0;
            r_heads   <= '0;
            r_pend    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_rows <= i_cfg_wr_data;
            if (w_in_acc) begin
                if (w_sat) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_col_cnt <= r_col_cnt + CW'(1);
                end
            end
            if (w_eval) begin
                r_cover <= m_next_cover;
                r_heads <= m_next_heads;
                r_pend  <= m_close_heads;
                r_any   <= r_any | (|m_close_heads);
            end
            if (w_emit && (r_state != S_MARK)) r_pend[w_top] <= 1'b0;
            // on the last column every span still open is handed out
            if (w_commit && r_fin && (r_heads != '0)) r_pend <= r_heads;
            if (w_clear) begin
                r_cover   <= '0;
                r_heads   <= '0;
                r_col_cnt <= '0;
                r_ovf     <= 1'b0;
                r_any     <= 1'b0;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_col  <= i_s_axis_tdata[LIVE_ROWS-1:0] & w_row_mask;
            r_fin  <= i_s_axis_tlast;
            r_idx  <= COL_FIELD_W'(w_idx);
            r_prev <= COL_FIELD_W'(w_prev);
        end
        if (w_eval) begin
            r_run_heads <= m_run_heads;
            r_ends      <= m_ends;
        end
        if (w_commit) begin
            // span ends of the updated open set, for the last-column sweep
            r_ends <= m_ends;
            for (int r = 0; r < LIVE_ROWS; r++) begin
                if (r_run_heads[r]) r_start_col[r] <= r_idx;
            end
        end
        if (w_emit) begin
            r_odata <= n_odata;
            r_ouser <= n_ouser;
            r_olast <= e_done;
        end
    end

endmodule

### design/grm_core_chk.sv
// port-level checks for the grid rectangle merger, bound to the top level
module grm_core_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_wr_en,
    input logic [grm_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic [grm_pkg::COLUMN_W-1:0]      i_s_axis_tdata,
    input logic                              i_s_axis_tlast,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [grm_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input logic [grm_pkg::OUT_USER_W-1:0]    o_m_axis_tuser,
    input logic                              o_m_axis_tlast
);
    import grm_pkg::*;

    // a column is worked on before the next one is taken
    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken again right after a column beat");

    // the empty marker is all zero and always ends the grid
    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[USER_RECT_BIT]) |->
        (o_m_axis_tlast && (o_m_axis_tdata == '0)))
        else $error("malformed end marker beat");

    // a rectangle never has its bottom row above its top row
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[USER_RECT_BIT]) |->
        (o_m_axis_tdata[OUT_BOT_LSB +: ROW_FIELD_W] >=
         o_m_axis_tdata[OUT_TOP_LSB +: ROW_FIELD_W]))
        else $error("rectangle row span reversed");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) &&
         $stable(o_m_axis_tlast)))
        else $error("output beat changed while stalled");

endmodule

bind grid_rectangle_merger_core grm_core_chk u_grm_core_chk (.*);

### verif/tb_top.sv
// self-checking testbench for grid_rectangle_merger_core with a built-in rectangle predictor
`timescale 1ns / 100ps

module tb_top;
    import grm_pkg::*;

    localparam int MAX_ROWS     = 32;
    localparam int MAX_COLS     = 256;
    localparam int MAX_RECTS    = 48;    // cap on rectangles queued from one column
    localparam int SETTLE_WAIT  = 100;   // cycles let pass after the last rectangle
    localparam int RUN_LIMIT    = 1000000;
    localparam int PRINT_CAP    = 40;

    typedef struct {
        logic [COLUMN_W-1:0] cells;
        logic                is_last;
        bit                  drain;      // hold this beat until no rectangle is owed
    } t_column_beat;

    typedef struct packed {
        logic [COL_FIELD_W-1:0] first_col;
        logic [COL_FIELD_W-1:0] last_col;
        logic [ROW_FIELD_W-1:0] top_row;
        logic [ROW_FIELD_W-1:0] bottom_row;
        logic                   rect_valid;
        logic                   grid_done;
        logic                   col_ovf;
    } t_rect;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic [COLUMN_W-1:0]    s_data = '0;
    logic                   s_last = 1'b0;
    logic                   m_ready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;
    logic [OUT_USER_W-1:0]  o_m_axis_tuser;
    logic                   o_m_axis_tlast;

    t_column_beat  pending_columns[$];
    t_rect         expected_rects[$];
    t_column_beat  next_beat;

    // predictor copy of the block state
    logic [CFG_W-1:0]        rows_cfg = ROWS_RESET;
    logic [MAX_ROWS-1:0]     open_cover = '0;
    logic [MAX_ROWS-1:0]     open_heads = '0;
    logic [COL_FIELD_W-1:0]  open_start[MAX_ROWS];
    int unsigned             col_count = 0;
    bit                      any_rect = 1'b0;
    bit                      col_ovf = 1'b0;

    bit  no_gaps = 1'b0;
    int  send_wait = 0;
    int  recv_wait = 0;
    int  cycle_count = 0;
    int  err_count = 0;
    int  columns_sent = 0;
    int  grids_sent = 0;
    int  rects_checked = 0;
    int  markers_checked = 0;
    int  ovf_checked = 0;

    grid_rectangle_merger_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("grid_rectangle_merger_core verification failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // ---------------- predictor ----------------

    function automatic logic [MAX_ROWS-1:0] used_rows_mask();
        int n;
        n = rows_cfg;
        if (n < 1) n = 1;
        if (n > MAX_ROWS) n = MAX_ROWS;
        return (n == MAX_ROWS) ? '1 : ((32'd1 << n) - 32'd1);
    endfunction

    // bottom row of the open rectangle headed at top
    function automatic int span_end(input int top);
        int r;
        r = top;
        while (r + 1 < MAX_ROWS && open_cover[r+1] && !open_heads[r+1]) r++;
        return r;
    endfunction

    function automatic logic [MAX_ROWS-1:0] span_bits(input int top, input int bot);
        logic [MAX_ROWS:0] hi;
        logic [MAX_ROWS:0] lo;
        hi = (33'd1 << (bot + 1)) - 33'd1;
        lo = (33'd1 << top) - 33'd1;
        return hi[MAX_ROWS-1:0] & ~lo[MAX_ROWS-1:0];
    endfunction

    function automatic t_rect make_rect(input logic [7:0] c0, input logic [7:0] c1,
                                        input int top, input int bot, input logic valid);
        t_rect r;
        r.first_col  = c0;
        r.last_col   = c1;
        r.top_row    = top[ROW_FIELD_W-1:0];
        r.bottom_row = bot[ROW_FIELD_W-1:0];
        r.rect_valid = valid;
        r.grid_done  = 1'b0;
        r.col_ovf    = col_ovf;
        return r;
    endfunction

    // one accepted column: grow or close the open rectangles, open new runs
    function automatic void merge_column(input logic [COLUMN_W-1:0] cells, input logic is_last);
        logic [MAX_ROWS-1:0]    col;
        logic [MAX_ROWS-1:0]    taken;
        logic [MAX_ROWS-1:0]    free_rows;
        logic [MAX_ROWS-1:0]    m;
        logic [COL_FIELD_W-1:0] idx;
        logic [COL_FIELD_W-1:0] prev;
        int                     bot;
        t_rect                  out[$];
        col   = cells[MAX_ROWS-1:0] & used_rows_mask();
        taken = '0;
        if (col_count >= MAX_COLS) begin
            col_ovf = 1'b1;
            idx     = COL_FIELD_W'(MAX_COLS - 1);
        end else begin
            idx = COL_FIELD_W'(col_count);
            col_count++;
        end
        prev = (idx != 0) ? idx - 1'b1 : '0;

        for (int r = 0; r < MAX_ROWS; r++) begin
            if (open_heads[r]) begin
                bot = span_end(r);
                m   = span_bits(r, bot);
                if ((col & m) == m) begin
                    taken |= m;
                end else begin
                    if (out.size() < MAX_RECTS) out = {out, make_rect(open_start[r], prev,
                                                                      r, bot, 1'b1)};
                    any_rect      = 1'b1;
                    open_cover   &= ~m;
                    open_heads[r] = 1'b0;
                end
            end
        end

        // a taken cell splits the remaining solid cells into separate runs
        free_rows = col & ~taken;
        for (int r = 0; r < MAX_ROWS; r++) begin
            if (free_rows[r]) begin
                bot = r;
                while (bot + 1 < MAX_ROWS && free_rows[bot+1]) bot++;
                open_heads[r] = 1'b1;
                open_cover   |= span_bits(r, bot);
                open_start[r] = idx;
                r = bot;
            end
        end

        if (is_last) begin
            for (int r = 0; r < MAX_ROWS; r++) begin
                if (open_heads[r]) begin
                    if (out.size() < MAX_RECTS) out = {out, make_rect(open_start[r], idx,
                                                                      r, span_end(r), 1'b1)};
                    any_rect = 1'b1;
                end
            end
            // grid with no solid cell at all: lone end marker
            if (!any_rect && out.size() < MAX_RECTS) out = {out, make_rect('0, '0, 0, 0, 1'b0)};
            if (out.size() > 0) out[out.size()-1].grid_done = 1'b1;
            open_cover = '0;
            open_heads = '0;
            foreach (open_start[i]) open_start[i] = '0;
            col_count = 0;
            any_rect  = 1'b0;
            col_ovf   = 1'b0;
        end
        foreach (out[i]) expected_rects = {expected_rects, out[i]};
    endfunction

    // ---------------- column driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid   <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                merge_column(s_data, s_last);
                columns_sent++;
                if (s_last) grids_sent++;
            end
            if (s_valid && !o_s_axis_tready) begin
                // beat holds until taken
            end else if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (pending_columns.size() > 0 &&
                         !(pending_columns[0].drain && expected_rects.size() > 0)) begin
                next_beat = pending_columns.pop_front();
                s_data    <= next_beat.cells;
                s_last    <= next_beat.is_last;
                s_valid   <= 1'b1;
                send_wait = no_gaps ? 0 : $urandom_range(0, 8);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- rectangle monitor ----------------

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) flag_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                if (expected_rects.size() == 0) begin
                    flag_error($sformatf("unexpected beat tdata %h tuser %b tlast %b",
                                         o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast));
                end else begin
                    t_rect want;
                    want = expected_rects.pop_front();
                    check_field("first_col", o_m_axis_tdata[OUT_FIRST_LSB +: COL_FIELD_W],
                                want.first_col);
                    check_field("last_col", o_m_axis_tdata[OUT_LAST_LSB +: COL_FIELD_W],
                                want.last_col);
                    check_field("top_row", o_m_axis_tdata[OUT_TOP_LSB +: ROW_FIELD_W],
                                want.top_row);
                    check_field("bottom_row", o_m_axis_tdata[OUT_BOT_LSB +: ROW_FIELD_W],
                                want.bottom_row);
                    check_field("rect_valid", o_m_axis_tuser[USER_RECT_BIT], want.rect_valid);
                    check_field("grid_done", o_m_axis_tlast, want.grid_done);
                    check_field("column_overflow", o_m_axis_tuser[USER_OVF_BIT], want.col_ovf);
                    if (want.rect_valid) rects_checked++;
                    else markers_checked++;
                    if (want.col_ovf) ovf_checked++;
                end
                recv_wait = no_gaps ? 0 : $urandom_range(0, 8);
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            m_ready <= (recv_wait == 0);
        end
    end

    // ---------------- stimulus ----------------

    task automatic push_column(input logic [31:0] cells, input logic is_last, input bit drain);
        t_column_beat b;
        b.cells   = cells;
        b.is_last = is_last;
        b.drain   = drain;
        pending_columns = {pending_columns, b};
    endtask

    // grid whose columns mostly repeat with small edits, so rectangles grow
    task automatic queue_grid(input int ncols, input int noise);
        logic [31:0] cells;
        int          style;
        int          pick;
        style = $urandom_range(0, 9);
        case (style)
            0: cells = '0;
            1: cells = '1;
            2: cells = $urandom() & $urandom();
            3: cells = $urandom() | $urandom();
            default: cells = $urandom();
        endcase
        for (int c = 0; c < ncols; c++) begin
            if (c > 0 && style != 0) begin
                pick = $urandom_range(0, 99);
                if (pick < noise) cells = $urandom();
                else if (pick < noise + 35) cells ^= (32'd1 << $urandom_range(0, 31));
                else if (pick < noise + 45) cells &= $urandom() | $urandom();
                else if (pick < noise + 50) cells |= $urandom() & $urandom();
            end
            push_column(cells, c == ncols - 1, c == 0 && $urandom_range(0, 19) == 0);
        end
    endtask

    task automatic wait_quiet();
        while (pending_columns.size() > 0 || s_valid) @(posedge i_clk);
        while (expected_rects.size() > 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_rows(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        rows_cfg = v;
    endtask

    logic [CFG_W-1:0] phase_rows[10];

    initial begin
        int added;
        int n;
        foreach (open_start[i]) open_start[i] = '0;
        // row settings per phase: reset value, both extremes, out of range both ways
        phase_rows = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd2, 6'd17, 6'd31, 6'd33, 6'd32, 6'd0};
        phase_rows[9] = CFG_W'($urandom_range(0, 63));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 10; p++) begin
            set_rows(phase_rows[p]);
            no_gaps = (p % 3 == 1);
            if (p == 0) begin
                push_column(32'h0000_0000, 1'b1, 1'b0);     // empty grid, lone marker
                push_column(32'hFFFF_FFFF, 1'b1, 1'b0);     // full single column
                // lower half grows, upper half opens beside it, then lower closes
                push_column(32'h0000_FFFF, 1'b0, 1'b0);
                push_column(32'hFFFF_FFFF, 1'b0, 1'b0);
                push_column(32'hFFFF_0000, 1'b0, 1'b1);     // sender waits for all results
                push_column(32'h0000_0000, 1'b0, 1'b0);
                push_column(32'hAAAA_AAAA, 1'b1, 1'b0);     // many one-row rectangles at end
                // everything closes before an empty last column: no done beat
                push_column(32'h5555_5555, 1'b0, 1'b0);
                push_column(32'h5555_5555, 1'b0, 1'b0);
                push_column(32'h0000_0000, 1'b0, 1'b0);
                push_column(32'h0000_0000, 1'b1, 1'b0);
                // several empty columns still end in one marker
                push_column(32'h0000_0000, 1'b0, 1'b0);
                push_column(32'h0000_0000, 1'b0, 1'b0);
                push_column(32'h0000_0000, 1'b1, 1'b0);
                // taken cells split the new solid cells into two runs
                push_column(32'h0000_00F0, 1'b0, 1'b0);
                push_column(32'h0000_0FFF, 1'b1, 1'b0);
                push_column(32'h8000_0001, 1'b1, 1'b0);     // first and last row
            end else if (p == 8) begin
                queue_grid(MAX_COLS + 4, 3);                // runs past the column counter
            end else begin
                added = 0;
                while (added < 20) begin
                    n = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 10);
                    queue_grid(n, 10);
                    added += n;
                end
            end
            wait_quiet();
        end

        $display("covered %0d columns in %0d grids over 10 row settings, one past the column limit",
                 columns_sent, grids_sent);
        $display("checked %0d rectangles, %0d end markers, %0d beats with overflow set",
                 rects_checked, markers_checked, ovf_checked);
        if (err_count == 0) begin
            $display("grid_rectangle_merger_core verification clean");
        end else begin
            $display("grid_rectangle_merger_core verification failed");
        end
        $finish;
    end

endmodule
